### hdl/regret_matching_node_assert.svh
// Assertion helpers shared by the regret matching node RTL.
`ifndef REGRET_MATCHING_NODE_ASSERT_SVH
`define REGRET_MATCHING_NODE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RMN_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("regret_matching_node: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RMN_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("regret_matching_node: check failed");

`endif

### hdl/rmn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmn_pkg
// Types and constants shared by the regret matching node.
// ----------------------------------------------------------------------------
package rmn_pkg;

    localparam int SLOTS = 8;
    localparam int SUM_W = 52;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_CUR = 2'd1;
    localparam logic [1:0] MODE_AVG = 2'd2;

    typedef struct packed {
        logic        [1:0]  mode;
        logic        [2:0]  action_index;
        logic signed [31:0] regret_delta;
        logic        [15:0] reach_weight;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  out_action;
        logic [15:0] probability;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic                 start;
        logic [SUM_W-1:0]     x;
        logic [SUM_W-1:0]     s;
    } div_req_t;

endpackage

### hdl/rmn_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmn_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface rmn_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/rmn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmn_front
// Accepts request items, drops those with no effect, queues the rest.
// ----------------------------------------------------------------------------
module rmn_front (
    input  logic              clk,
    input  logic              rst_n,
    rmn_chan_if.sink          req,
    input  logic [3:0]        n,
    output rmn_pkg::in_item_t cmd,
    output logic              cmd_valid,
    input  logic              cmd_ready
);
    import rmn_pkg::*;
    `include "regret_matching_node_assert.svh"

    in_item_t   q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       keep;
    logic       push;
    logic       pop;

    always_comb
    begin
        unique case (req.data.mode)
            MODE_ADD: keep = {1'b0, req.data.action_index} < n;
            MODE_CUR: keep = 1'b1;
            MODE_AVG: keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= req.data;
    end

    `RMN_CHECK(q_bound, 1'b1, cnt_reg <= 2'd2)
    `RMN_CHECK_NEXT(q_full_stalls, cnt_reg == 2'd2 && !cmd_ready, !req.ready)

endmodule

### hdl/rmn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmn_div
// Restoring divider for floor(x * 2^F / s), x <= s, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rmn_div #(
    parameter int PROB_FRAC_BITS = 15
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rmn_pkg::div_req_t         dreq,
    output logic                      done,
    output logic [PROB_FRAC_BITS:0]   q
);
    import rmn_pkg::*;

    localparam int QW = PROB_FRAC_BITS + 1;
    localparam int CW = $clog2(PROB_FRAC_BITS + 2);

    logic [SUM_W:0]   r_reg;
    logic [SUM_W-1:0] s_reg;
    logic [QW-1:0]    q_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic             ge;
    logic [SUM_W:0]   diff;

    assign ge   = r_reg >= {1'b0, s_reg};
    assign diff = ge ? (r_reg - {1'b0, s_reg}) : r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (dreq.start)
                cnt_reg <= CW'(QW);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dreq.start)
        begin
            r_reg <= {1'b0, dreq.x};
            s_reg <= dreq.s;
            q_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            r_reg <= {diff[SUM_W-1:0], 1'b0};
            q_reg <= {q_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

### hdl/rmn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmn_back
// Holds regret and strategy totals and carries out queued items.
// ----------------------------------------------------------------------------
module rmn_back #(
    parameter int PROB_FRAC_BITS = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rmn_pkg::in_item_t cmd,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [3:0]        n,
    rmn_chan_if.source        rsp
);
    import rmn_pkg::*;
    `include "regret_matching_node_assert.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADD  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_PUT  = 3'd5;

    logic [2:0]         state_reg;
    logic [2:0]         k_reg;
    logic [SUM_W-1:0]   sum_reg;
    in_item_t           cmd_reg;
    logic signed [31:0] regret_reg [SLOTS];
    logic [47:0]        strat_reg  [SLOTS];
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic [2:0]         idx;
    logic signed [31:0] rd_regret;
    logic [47:0]        rd_strat;
    logic [SUM_W-1:0]   val_k;
    logic signed [32:0] add_sum;
    logic signed [31:0] add_sat;
    logic [2:0]         last_k;
    logic               is_last;
    logic               out_free;
    div_req_t           dreq;
    logic               div_done;
    logic [PROB_FRAC_BITS:0] div_q;
    logic [63:0]        q_ext;
    logic [15:0]        prob;
    logic [31:0]        prod;
    logic [48:0]        strat_sum;
    logic [47:0]        strat_sat;

    rmn_div #(.PROB_FRAC_BITS(PROB_FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .dreq  (dreq),
        .done  (div_done),
        .q     (div_q)
    );

    assign idx       = (state_reg == ST_ADD) ? cmd_reg.action_index : k_reg;
    assign rd_regret = regret_reg[idx];
    assign rd_strat  = strat_reg[k_reg];
    assign val_k     = (cmd_reg.mode == MODE_CUR)
                     ? ((rd_regret > 0) ? SUM_W'(unsigned'(rd_regret)) : '0)
                     : SUM_W'(rd_strat);

    assign add_sum = 33'(rd_regret) + 33'(cmd_reg.regret_delta);
    always_comb
    begin
        if (add_sum > 33'sd2147483647)
            add_sat = 32'sh7FFFFFFF;
        else if (add_sum < -33'sd2147483648)
            add_sat = 32'sh80000000;
        else
            add_sat = add_sum[31:0];
    end

    assign last_k   = 3'(n - 4'd1);
    assign is_last  = (k_reg == last_k);
    assign out_free = !out_valid_reg || rsp.ready;

    assign dreq.start = (state_reg == ST_DIV);
    assign dreq.x     = (sum_reg == '0) ? SUM_W'(1) : val_k;
    assign dreq.s     = (sum_reg == '0) ? SUM_W'(n) : sum_reg;

    assign q_ext     = 64'(div_q);
    assign prob      = q_ext[15:0];
    assign prod      = cmd_reg.reach_weight * prob;
    assign strat_sum = {1'b0, rd_strat} + 49'(prod);
    assign strat_sat = strat_sum[48] ? {48{1'b1}} : strat_sum[47:0];

    assign cmd_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                regret_reg[i] <= '0;
                strat_reg[i]  <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        k_reg     <= '0;
                        state_reg <= (cmd.mode == MODE_ADD) ? ST_ADD : ST_SUM;
                    end
                end
                ST_ADD:
                begin
                    regret_reg[idx] <= add_sat;
                    state_reg       <= ST_IDLE;
                end
                ST_SUM:
                begin
                    if (is_last)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_DIV;
                    end
                    else
                        k_reg <= k_reg + 3'd1;
                end
                ST_DIV:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (div_done)
                        state_reg <= ST_PUT;
                end
                ST_PUT:
                begin
                    if (out_free)
                    begin
                        if (cmd_reg.mode == MODE_CUR)
                            strat_reg[k_reg] <= strat_sat;
                        if (is_last)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
            if (state_reg == ST_PUT && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
        begin
            cmd_reg <= cmd;
            sum_reg <= '0;
        end
        else if (state_reg == ST_SUM)
            sum_reg <= sum_reg + val_k;
        if (state_reg == ST_PUT && out_free)
        begin
            out_reg.out_action  <= k_reg;
            out_reg.probability <= prob;
            out_reg.last        <= is_last;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    `RMN_CHECK(last_on_final, out_valid_reg && out_reg.last, out_reg.out_action == last_k)
    `RMN_CHECK_NEXT(put_loads, state_reg == ST_PUT && out_free, out_valid_reg)
    `RMN_CHECK(div_only_busy, div_done, state_reg == ST_WAIT)

endmodule

### hdl/regret_matching_node.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regret_matching_node
// Regret matching store for one decision node of a CFR solver.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on req. Mode 0 adds a signed Q16.16 delta to one action's
// regret total with saturation and gives no result. Mode 1 gives the current
// strategy from the positive regrets and adds reach weight times probability
// to each strategy total. Mode 2 gives the average strategy. Modes 1 and 2
// give one result item per action on rsp, action 0 first, last set on the end.
// The cfg channel writes action_count; it is always ready and must only be
// written while the node is idle.
// Modes 1 and 2 run a serial divider that gives one quotient bit a cycle.
// A two-entry queue between the front and back sides lets req keep
// accepting while the queue has room, also while the back side works or rsp
// is stalled; a stalled rsp holds its result and the back side waits. Reset
// clears all totals to zero and sets action_count to one.
// ----------------------------------------------------------------------------
module regret_matching_node #(
    parameter int MAX_ACTIONS    = 8,
    parameter int PROB_FRAC_BITS = 15
) (
    input  logic     clk,
    input  logic     rst_n,
    rmn_chan_if.sink   req,
    rmn_chan_if.source rsp,
    rmn_chan_if.sink   cfg
);
    import rmn_pkg::*;

    // Upper clamp for the action count: the store has eight slots.
    localparam int NMAX = (MAX_ACTIONS < SLOTS) ? MAX_ACTIONS : SLOTS;

    logic [3:0] action_count_reg;
    logic [3:0] n;
    in_item_t   cmd;
    logic       cmd_valid;
    logic       cmd_ready;

    // The configuration write is taken on any cycle.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            action_count_reg <= 4'd1;
        else if (cfg.valid)
            action_count_reg <= cfg.data;
    end

    // Zero acts as one action and counts above the limit act as the limit.
    always_comb
    begin
        if (action_count_reg == 4'd0)
            n = 4'd1;
        else if (action_count_reg > 4'(NMAX))
            n = 4'(NMAX);
        else
            n = action_count_reg;
    end

    rmn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .n         (n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    rmn_back #(.PROB_FRAC_BITS(PROB_FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .n         (n),
        .rsp       (rsp)
    );

endmodule
